// ----- src/adp_pkg.sv -----
// Shared types and constants for the Art-Net datagram parser.
// Used by adp_parser and artnet_datagram_parser_unit; no dependencies.
`default_nettype none

package adp_pkg;

  // Art-Net opcodes (little-endian on the wire).
  localparam logic [15:0] OP_DMX     = 16'h5000;
  localparam logic [15:0] OP_POLL    = 16'h2000;
  localparam logic [15:0] OP_ADDRESS = 16'h6000;

  // Configuration register indexes.
  localparam int unsigned CfgIdxW = 8;
  localparam logic [CfgIdxW-1:0] CFG_LAYER_EN   = 8'd0;
  localparam logic [CfgIdxW-1:0] CFG_ARTNET_EN  = 8'd1;
  localparam logic [CfgIdxW-1:0] CFG_ALLOW_ADDR = 8'd2;
  localparam logic [CfgIdxW-1:0] CFG_PORT_ADDR  = 8'd3;
  localparam int unsigned CfgDataW = 15;

  localparam logic [7:0] ADDR_CMD_CANCEL_MERGE = 8'h01;

  typedef enum logic [2:0] {
    VERDICT_IGNORED    = 3'd0,
    VERDICT_DMX_OK     = 3'd1,
    VERDICT_DMX_DROP   = 3'd2,
    VERDICT_POLL_REPLY = 3'd3,
    VERDICT_ADDR_APPLY = 3'd4,
    VERDICT_ADDR_REFUSE = 3'd5
  } adp_verdict_e;

  typedef struct packed {
    logic         kind;
    logic [8:0]   slot_index;
    logic [7:0]   slot_value;
    adp_verdict_e verdict;
    logic [9:0]   slot_count;
    logic [31:0]  frame_source;
    logic [14:0]  port_address_now;
    logic         cancel_merge;
    logic         last;
  } adp_result_t;

  // Expected byte of the "Art-Net\0" identifier at a header position.
  function automatic logic [7:0] id_byte(input logic [2:0] idx);
    logic [7:0] val;
    unique case (idx)
      3'd0: val = 8'h41;
      3'd1: val = 8'h72;
      3'd2: val = 8'h74;
      3'd3: val = 8'h2d;
      3'd4: val = 8'h4e;
      3'd5: val = 8'h65;
      3'd6: val = 8'h74;
      3'd7: val = 8'h00;
    endcase
    return val;
  endfunction

endpackage

`default_nettype wire

// ----- src/artnet_datagram_parser_unit.sv -----
// Top level of the Art-Net datagram parser: input register, parser and result queue.
// Depends on adp_pkg, adp_parser and adp_result_fifo.
//
// The block takes one datagram byte per clock cycle on the slave stream and
// registers it; when the queue has room the parser updates its header state
// and emits zero, one or two results into a four-entry result queue that
// feeds the master stream. A byte is taken in every cycle as long as the queue
// has room for two results, so input runs at one byte per cycle. Only the
// last byte of an ArtDmx frame that still streams a slot yields two results,
// which the output drains one per cycle while the master stream is ready. The
// configuration port is always ready and must be written only while no
// datagram is in flight.
`default_nettype none

module artnet_datagram_parser_unit #(
  parameter int unsigned POSITION_LIMIT = 2047
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         s_axis_tvalid,
  output logic                              s_axis_tready,
  // tdata: [7:0] data_byte, [39:8] source_addr
  input  wire logic [39:0]                  s_axis_tdata,
  input  wire logic                         s_axis_tlast,
  output logic                              m_axis_tvalid,
  input  wire logic                         m_axis_tready,
  // tdata: [8:0] slot_index, [16:9] slot_value, [19:17] verdict, [29:20] slot_count,
  //        [61:30] frame_source, [76:62] port_address_now, [77] cancel_merge, [79:78] zero
  output logic [79:0]                       m_axis_tdata,
  // tuser: [0] kind
  output logic                              m_axis_tuser,
  output logic                              m_axis_tlast,
  input  wire logic                         cfg_valid_i,
  output logic                              cfg_ready_o,
  input  wire logic [adp_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [adp_pkg::CfgDataW-1:0] cfg_data_i
);

  import adp_pkg::*;

  localparam int unsigned ResW = $bits(adp_result_t);

  logic        in_valid_q;
  logic [7:0]  byte_q;
  logic        last_q;
  logic [31:0] src_q;
  logic        space, step;
  logic        res_a_valid, res_b_valid;
  adp_result_t res_a, res_b, head;
  logic [ResW-1:0] head_bits;

  assign cfg_ready_o   = 1'b1;
  assign step          = in_valid_q && space;
  assign s_axis_tready = !in_valid_q || step;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      byte_q <= s_axis_tdata[7:0];
      src_q  <= s_axis_tdata[39:8];
      last_q <= s_axis_tlast;
    end
  end

  adp_parser #(
    .PositionLimit(POSITION_LIMIT)
  ) u_parser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_valid_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .step_i       (step),
    .data_byte_i  (byte_q),
    .last_byte_i  (last_q),
    .source_addr_i(src_q),
    .res_a_valid_o(res_a_valid),
    .res_a_o      (res_a),
    .res_b_valid_o(res_b_valid),
    .res_b_o      (res_b)
  );

  adp_result_fifo #(
    .Width(ResW),
    .Depth(4)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_a_i(res_a_valid),
    .data_a_i(res_a),
    .push_b_i(res_b_valid),
    .data_b_i(res_b),
    .space_o (space),
    .valid_o (m_axis_tvalid),
    .ready_i (m_axis_tready),
    .data_o  (head_bits)
  );

  assign head         = adp_result_t'(head_bits);
  assign m_axis_tuser = head.kind;
  assign m_axis_tlast = head.last;
  assign m_axis_tdata = {2'b00, head.cancel_merge, head.port_address_now, head.frame_source,
                         head.slot_count, head.verdict, head.slot_value, head.slot_index};

endmodule

`default_nettype wire

// ----- src/adp_result_fifo.sv -----
// Small result queue that takes up to two results per cycle and gives one.
// Depends on nothing; the payload is an opaque vector.
`default_nettype none

module adp_result_fifo #(
  parameter int unsigned Width = 80,
  parameter int unsigned Depth = 4
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_a_i,
  input  wire logic [Width-1:0] data_a_i,
  input  wire logic             push_b_i,
  input  wire logic [Width-1:0] data_b_i,
  output logic                  space_o,
  output logic                  valid_o,
  input  wire logic             ready_i,
  output logic [Width-1:0]      data_o
);

  // Depth must be a power of two so the pointers wrap naturally.
  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  count_q, count_d;
  logic             pop;
  logic [PtrW-1:0]  wr_ptr_b;

  assign pop      = valid_o & ready_i;
  assign valid_o  = (count_q != '0);
  assign data_o   = mem_q[rd_ptr_q];
  assign space_o  = (count_q <= CntW'(Depth - 2));
  assign wr_ptr_b = wr_ptr_q + PtrW'(1);

  always_comb begin
    wr_ptr_d = wr_ptr_q + PtrW'(push_a_i) + PtrW'(push_b_i);
    rd_ptr_d = rd_ptr_q + PtrW'(pop);
    count_d  = count_q + CntW'(push_a_i) + CntW'(push_b_i) - CntW'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_a_i) begin
      mem_q[wr_ptr_q] <= data_a_i;
    end
    if (push_b_i) begin
      mem_q[wr_ptr_b] <= data_b_i;
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(Depth))
    else $error("result queue count exceeds its depth");

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_a_i || push_b_i) |-> $past(space_o) || !$past(rst_ni) || count_q <= CntW'(Depth - 2)
      || pop)
    else $error("result queue pushed without room");

  a_pop_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && !push_a_i && !push_b_i) |=> count_q == $past(count_q) - CntW'(1))
    else $error("result queue count did not drop on a lone pop");

endmodule

`default_nettype wire

// ----- src/adp_parser.sv -----
// Datagram state, configuration registers and per-byte result logic.
// Depends on adp_pkg for opcodes, register indexes and the result type.
`default_nettype none

module adp_parser #(
  parameter int unsigned PositionLimit = 2047
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [adp_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  wire logic [adp_pkg::CfgDataW-1:0]   cfg_data_i,
  input  wire logic                           step_i,
  input  wire logic [7:0]                     data_byte_i,
  input  wire logic                           last_byte_i,
  input  wire logic [31:0]                    source_addr_i,
  output logic                                res_a_valid_o,
  output adp_pkg::adp_result_t                res_a_o,
  output logic                                res_b_valid_o,
  output adp_pkg::adp_result_t                res_b_o
);

  import adp_pkg::*;

  localparam int unsigned PosW = $clog2(PositionLimit + 1);
  localparam int unsigned WideW = 17;

  logic            layer_en_q, artnet_en_q, allow_addr_q;
  logic [14:0]     init_addr_q, cur_addr_q, cur_addr_d;
  logic [PosW-1:0] pos_q, pos_d, total;
  logic            id_q, id_d, id_n;
  logic [15:0]     op_q, op_d, op_n, len_q, len_d, len_n;
  logic [7:0]      uni_q, uni_d, uni_n, net_q, net_d, net_n;
  logic [7:0]      nsw_q, nsw_d, nsw_n, osw_q, osw_d, osw_n;
  logic [7:0]      ssw_q, ssw_d, ssw_n, cmd_q, cmd_d, cmd_n;
  logic [31:0]     sender_q, sender_d;
  logic            live, hdr_ok, slot_hit, done;
  logic [WideW-1:0] pos_w, slot_off, total_w;
  adp_verdict_e    verdict;
  logic            applied;
  logic [6:0]      new_net;
  logic [3:0]      new_sub, new_uni;
  logic [14:0]     applied_addr;
  logic [14:0]     addr_after;

  always_comb begin
    live     = step_i && (pos_q != PosW'(PositionLimit));
    done     = step_i && last_byte_i;
    sender_d = (step_i && pos_q == '0) ? source_addr_i : sender_q;

    // Header capture by byte position.
    id_n  = id_q;
    op_n  = op_q;
    len_n = len_q;
    uni_n = uni_q;
    net_n = net_q;
    nsw_n = nsw_q;
    osw_n = osw_q;
    ssw_n = ssw_q;
    cmd_n = cmd_q;
    if (live) begin
      if (pos_q < PosW'(8)) begin
        if (data_byte_i != id_byte(pos_q[2:0])) begin
          id_n = 1'b0;
        end
      end
      if (pos_q == PosW'(8))   op_n[7:0]   = data_byte_i;
      if (pos_q == PosW'(9))   op_n[15:8]  = data_byte_i;
      if (pos_q == PosW'(12))  nsw_n       = data_byte_i;
      if (pos_q == PosW'(14))  uni_n       = data_byte_i;
      if (pos_q == PosW'(15))  net_n       = data_byte_i;
      if (pos_q == PosW'(16))  len_n[15:8] = data_byte_i;
      if (pos_q == PosW'(17))  len_n[7:0]  = data_byte_i;
      if (pos_q == PosW'(100)) osw_n       = data_byte_i;
      if (pos_q == PosW'(104)) ssw_n       = data_byte_i;
      if (pos_q == PosW'(106)) cmd_n       = data_byte_i;
    end

    total   = live ? pos_q + PosW'(1) : pos_q;
    pos_w   = WideW'(pos_q);
    total_w = WideW'(total);
    slot_off = pos_w - WideW'(18);

    hdr_ok = layer_en_q && artnet_en_q && (len_n >= 16'd2) && (len_n <= 16'd512)
             && ({net_n[6:0], uni_n} == cur_addr_q);

    slot_hit = live && (pos_q >= PosW'(18)) && id_n && (op_n == OP_DMX) && hdr_ok
               && (slot_off < WideW'(len_n));

    // Switch bytes with bit 7 set replace the matching address field.
    new_net = nsw_n[7] ? nsw_n[6:0] : cur_addr_q[14:8];
    new_sub = ssw_n[7] ? ssw_n[3:0] : cur_addr_q[7:4];
    new_uni = osw_n[7] ? osw_n[3:0] : cur_addr_q[3:0];
    applied_addr = {new_net, new_sub, new_uni};

    verdict = VERDICT_IGNORED;
    applied = 1'b0;
    if (total_w >= WideW'(10) && id_n) begin
      if (op_n == OP_DMX) begin
        if (total_w >= WideW'(18) && hdr_ok && total_w >= WideW'(18) + WideW'(len_n)) begin
          verdict = VERDICT_DMX_OK;
        end else begin
          verdict = VERDICT_DMX_DROP;
        end
      end else if (op_n == OP_POLL) begin
        if (total_w >= WideW'(14)) begin
          verdict = VERDICT_POLL_REPLY;
        end
      end else if (op_n == OP_ADDRESS) begin
        if (total_w >= WideW'(107)) begin
          if (allow_addr_q) begin
            verdict = VERDICT_ADDR_APPLY;
            applied = 1'b1;
          end else begin
            verdict = VERDICT_ADDR_REFUSE;
          end
        end
      end
    end

    addr_after = (done && applied) ? applied_addr : cur_addr_q;
    // A write to the port address register reloads the current address.
    cur_addr_d = (cfg_we_i && cfg_index_i == CFG_PORT_ADDR) ? cfg_data_i : addr_after;

    res_b_o.kind             = 1'b1;
    res_b_o.slot_index       = '0;
    res_b_o.slot_value       = '0;
    res_b_o.verdict          = verdict;
    res_b_o.slot_count       = (verdict == VERDICT_DMX_OK) ? len_n[9:0] : 10'd0;
    res_b_o.frame_source     = sender_d;
    res_b_o.port_address_now = addr_after;
    res_b_o.cancel_merge     = applied && (cmd_n == ADDR_CMD_CANCEL_MERGE);
    res_b_o.last             = 1'b1;

    // A slot result goes first; the verdict follows it when both occur.
    if (slot_hit) begin
      res_a_o.kind             = 1'b0;
      res_a_o.slot_index       = slot_off[8:0];
      res_a_o.slot_value       = data_byte_i;
      res_a_o.verdict          = VERDICT_IGNORED;
      res_a_o.slot_count       = '0;
      res_a_o.frame_source     = sender_d;
      res_a_o.port_address_now = cur_addr_q;
      res_a_o.cancel_merge     = 1'b0;
      res_a_o.last             = !last_byte_i;
    end else begin
      res_a_o = res_b_o;
    end
    res_a_valid_o = slot_hit || done;
    res_b_valid_o = slot_hit && done;

    if (done) begin
      pos_d = '0;
      id_d  = 1'b1;
      op_d  = '0;
      len_d = '0;
      uni_d = '0;
      net_d = '0;
      nsw_d = '0;
      osw_d = '0;
      ssw_d = '0;
      cmd_d = '0;
    end else begin
      pos_d = total;
      id_d  = id_n;
      op_d  = op_n;
      len_d = len_n;
      uni_d = uni_n;
      net_d = net_n;
      nsw_d = nsw_n;
      osw_d = osw_n;
      ssw_d = ssw_n;
      cmd_d = cmd_n;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      layer_en_q   <= 1'b1;
      artnet_en_q  <= 1'b1;
      allow_addr_q <= 1'b0;
      init_addr_q  <= '0;
      cur_addr_q   <= '0;
      pos_q        <= '0;
      id_q         <= 1'b1;
      op_q         <= '0;
      len_q        <= '0;
      uni_q        <= '0;
      net_q        <= '0;
      nsw_q        <= '0;
      osw_q        <= '0;
      ssw_q        <= '0;
      cmd_q        <= '0;
      sender_q     <= '0;
    end else begin
      pos_q    <= pos_d;
      id_q     <= id_d;
      op_q     <= op_d;
      len_q    <= len_d;
      uni_q    <= uni_d;
      net_q    <= net_d;
      nsw_q    <= nsw_d;
      osw_q    <= osw_d;
      ssw_q    <= ssw_d;
      cmd_q    <= cmd_d;
      sender_q <= sender_d;
      cur_addr_q <= cur_addr_d;
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          CFG_LAYER_EN:   layer_en_q   <= cfg_data_i[0];
          CFG_ARTNET_EN:  artnet_en_q  <= cfg_data_i[0];
          CFG_ALLOW_ADDR: allow_addr_q <= cfg_data_i[0];
          CFG_PORT_ADDR:  init_addr_q  <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  a_pair_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_b_valid_o |-> res_a_valid_o && !res_a_o.kind && !res_a_o.last && res_b_o.kind)
    else $error("two results in one cycle must be a slot then a verdict");

  a_verdict_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done |-> res_a_valid_o && (res_a_o.kind || res_b_valid_o))
    else $error("last byte produced no verdict");

  a_clear_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done |=> pos_q == '0 && id_q)
    else $error("datagram state not cleared after the last byte");

  a_init_tracks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cfg_we_i && cfg_index_i == CFG_PORT_ADDR) |=> cur_addr_q == init_addr_q)
    else $error("port address not loaded by its register write");

endmodule

`default_nettype wire
